>>> sv/lfcd_pkg.sv
// Shared types and constants for the LUT file checker and decoder.
package lfcd_pkg;

    localparam int HEADER_BYTES  = 128;
    localparam int FRACTION_BITS = 16;

    localparam logic [31:0] FILE_MAGIC = 32'h4234_0299;

    localparam int CODE_W    = 10;
    localparam int INDEX_W   = 30;
    localparam int VALUE_W   = 17;
    localparam int STATUS_W  = 3;
    localparam int CODE_FULL = 1008;
    localparam int CODE_HALF = CODE_FULL / 2;

    // 1008 = 16 * 63: shift off the 16, multiply by a reciprocal of 63
    localparam int DIV_SH  = 4;
    localparam int DIV_ODD = CODE_FULL / (1 << DIV_SH);
    localparam int ODD_SH  = 6;

    localparam int NUM_W  = CODE_W + 1 + FRACTION_BITS;
    localparam int X_W    = NUM_W - DIV_SH;
    localparam int RSH    = X_W + ODD_SH;
    localparam int PROD_W = 2 * X_W + 1;
    localparam int Q_W    = PROD_W - RSH;
    localparam logic [X_W:0] RECIP =
        (X_W + 1)'(((64'd1 << RSH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD));

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HDR_SUM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DATA_SUM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd4;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = $clog2(OUT_DEPTH);
    localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic                    has_entry;
        logic [INDEX_W-1:0]      index;
        logic [3*CODE_W-1:0]     word;
        logic                    has_status;
        logic [STATUS_W-1:0]     status;
    } t_cmd;

    typedef struct packed {
        logic                    kind;
        logic [INDEX_W-1:0]      index;
        logic [VALUE_W-1:0]      red;
        logic [VALUE_W-1:0]      green;
        logic [VALUE_W-1:0]      blue;
        logic [STATUS_W-1:0]     status;
        logic                    last;
    } t_res;

endpackage

>>> sv/lfcd_front.sv
// Front end: parse header and data bytes, emit entry and status commands.
module lfcd_front
    import lfcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    input  logic        i_end_of_stream,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    localparam logic [31:0] MAGIC_END = 32'd4;
    localparam logic [31:0] SUM_POS   = 32'd40;
    localparam logic [31:0] LEN_POS   = 32'd44;
    localparam logic [31:0] LEN_END   = 32'd48;
    localparam logic [31:0] HDR_LAST  = 32'(HEADER_BYTES - 1);

    t_phase              r_phase, n_phase;
    logic [31:0]         r_pos, n_pos;
    logic [7:0]          r_hsum, n_hsum;
    logic [31:0]         r_magic, n_magic;
    logic [31:0]         r_exp, n_exp;
    logic [31:0]         r_len, n_len;
    logic [31:0]         r_dsum, n_dsum;
    logic [23:0]         r_wa, n_wa;
    logic [INDEX_W-1:0]  r_ecnt, n_ecnt;

    logic                in_hdr, in_data;
    logic [31:0]         dsum_add;
    t_cmd                cmd;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_hsum   = r_hsum;
        n_magic  = r_magic;
        n_exp    = r_exp;
        n_len    = r_len;
        n_dsum   = r_dsum;
        n_wa     = r_wa;
        n_ecnt   = r_ecnt;
        cmd      = '0;
        in_hdr   = i_start_of_file || (r_phase == PH_HEADER);
        in_data  = !i_start_of_file && (r_phase == PH_DATA);
        dsum_add = r_dsum + 32'(i_data_byte);
        if (i_accept) begin
            if (i_start_of_file) begin
                n_phase = PH_HEADER;
                n_pos   = '0;
                n_hsum  = '0;
                n_magic = '0;
                n_exp   = '0;
                n_len   = '0;
                n_dsum  = '0;
                n_wa    = '0;
                n_ecnt  = '0;
            end
            if (in_hdr) begin
                if (i_start_of_file || (r_pos < HDR_LAST)) begin
                    n_hsum = n_hsum + i_data_byte;
                    if (n_pos < MAGIC_END) begin
                        n_magic = {i_data_byte, n_magic[31:8]};
                    end else if (n_pos >= SUM_POS && n_pos < LEN_POS) begin
                        n_exp = {i_data_byte, n_exp[31:8]};
                    end else if (n_pos >= LEN_POS && n_pos < LEN_END) begin
                        n_len = {i_data_byte, n_len[31:8]};
                    end
                    n_pos = n_pos + 32'd1;
                    if (i_end_of_stream) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_TRUNC;
                    end
                end else if (r_magic != FILE_MAGIC) begin
                    cmd.has_status = 1'b1;
                    cmd.status     = ST_BAD_MAGIC;
                end else if (r_hsum != i_data_byte) begin
                    cmd.has_status = 1'b1;
                    cmd.status     = ST_HDR_SUM;
                end else if (r_len == 32'd0) begin
                    cmd.has_status = 1'b1;
                    cmd.status     = (r_dsum == r_exp) ? ST_OK : ST_DATA_SUM;
                end else begin
                    n_phase = PH_DATA;
                    n_pos   = '0;
                    if (i_end_of_stream) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_TRUNC;
                    end
                end
            end else if (in_data) begin
                n_dsum = dsum_add;
                case (r_pos[1:0])
                    2'd0: begin
                        n_wa = {16'd0, i_data_byte};
                    end
                    2'd1: begin
                        n_wa = r_wa | {8'd0, i_data_byte, 8'd0};
                    end
                    2'd2: begin
                        n_wa = r_wa | {i_data_byte, 16'd0};
                    end
                    default: begin
                        cmd.has_entry = 1'b1;
                        cmd.index     = r_ecnt;
                        cmd.word      = {i_data_byte[5:0], r_wa};
                        n_ecnt        = r_ecnt + INDEX_W'(1);
                    end
                endcase
                if (r_pos == r_len - 32'd1) begin
                    cmd.has_status = 1'b1;
                    cmd.status     = (dsum_add == r_exp) ? ST_OK : ST_DATA_SUM;
                end else begin
                    n_pos = r_pos + 32'd1;
                    if (i_end_of_stream) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_TRUNC;
                    end
                end
            end
            if (cmd.has_status) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_hsum  <= '0;
            r_magic <= '0;
            r_exp   <= '0;
            r_len   <= '0;
            r_dsum  <= '0;
            r_wa    <= '0;
            r_ecnt  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_hsum  <= n_hsum;
            r_magic <= n_magic;
            r_exp   <= n_exp;
            r_len   <= n_len;
            r_dsum  <= n_dsum;
            r_wa    <= n_wa;
            r_ecnt  <= n_ecnt;
        end
    end

    assign o_cmd_push = i_accept && (cmd.has_entry || cmd.has_status);
    assign o_cmd      = cmd;

endmodule

>>> sv/lfcd_cmdq.sv
// Short command queue between the front end and the back end.
module lfcd_cmdq
    import lfcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output t_cmd  o_cmd,
    output logic  o_empty
);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wp, r_rp;
    logic [CMDQ_CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + CMDQ_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + CMDQ_CW'(i_push) - CMDQ_CW'(i_pop);
        end
    end

    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

endmodule

>>> sv/lfcd_back.sv
// Back end: split commands into results, scale codes, buffer result words.
module lfcd_back
    import lfcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  logic  i_cmd_empty,
    output logic  o_cmd_pop,
    input  logic  i_pop,
    output logic  o_empty,
    output t_res  o_res
);

    logic                r_ent_done;
    logic [OUT_CW-1:0]   r_used;

    logic                can, issue_ent, issue_st, out_pop;
    logic [CODE_W-1:0]   code [3];
    logic [NUM_W-1:0]    num  [3];
    logic [X_W-1:0]      x    [3];
    logic [PROD_W-1:0]   prod [3];

    logic                r_s1_v;
    t_res                r_s1_res;
    logic [X_W-1:0]      r_s1_x    [3];
    logic [PROD_W-1:0]   r_s1_prod [3];

    logic [Q_W-1:0]      q0  [3];
    logic [X_W-1:0]      rem [3];
    logic [Q_W-1:0]      q   [3];
    t_res                s2_res;

    t_res                r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]   r_wp, r_rp;
    logic [OUT_CW-1:0]   r_cnt;

    assign can       = !i_cmd_empty && (r_used < OUT_CW'(OUT_DEPTH));
    assign issue_ent = can && i_cmd.has_entry && !r_ent_done;
    assign issue_st  = can && !issue_ent;
    assign o_cmd_pop = issue_st || (issue_ent && !i_cmd.has_status);
    assign out_pop   = i_pop && !o_empty;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            code[l] = issue_ent ? i_cmd.word[l*CODE_W +: CODE_W] : '0;
            num[l]  = (NUM_W'(code[l]) << FRACTION_BITS) + NUM_W'(CODE_HALF);
            x[l]    = num[l][NUM_W-1:DIV_SH];
            prod[l] = PROD_W'(x[l]) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_res.kind   <= issue_ent ? KIND_ENTRY : KIND_STATUS;
        r_s1_res.index  <= issue_ent ? i_cmd.index : '0;
        r_s1_res.status <= issue_ent ? ST_OK : i_cmd.status;
        r_s1_res.last   <= !issue_ent;
        r_s1_res.red    <= '0;
        r_s1_res.green  <= '0;
        r_s1_res.blue   <= '0;
        r_s1_x          <= x;
        r_s1_prod       <= prod;
    end

    // correct the reciprocal estimate by one compare and add
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            q0[l]  = r_s1_prod[l][PROD_W-1:RSH];
            rem[l] = r_s1_x[l] - ((X_W'(q0[l]) << ODD_SH) - X_W'(q0[l]));
            q[l]   = (rem[l] >= X_W'(DIV_ODD)) ? q0[l] + Q_W'(1) : q0[l];
        end
        s2_res       = r_s1_res;
        s2_res.red   = VALUE_W'(q[0]);
        s2_res.green = VALUE_W'(q[1]);
        s2_res.blue  = VALUE_W'(q[2]);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_mem[r_wp] <= s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_done <= 1'b0;
            r_used     <= '0;
            r_s1_v     <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            if (issue_ent && i_cmd.has_status) begin
                r_ent_done <= 1'b1;
            end else if (issue_st) begin
                r_ent_done <= 1'b0;
            end
            r_used <= r_used + OUT_CW'(can) - OUT_CW'(out_pop);
            r_s1_v <= can;
            if (r_s1_v) begin
                r_wp <= r_wp + OUT_AW'(1);
            end
            if (out_pop) begin
                r_rp <= r_rp + OUT_AW'(1);
            end
            r_cnt <= r_cnt + OUT_CW'(r_s1_v) - OUT_CW'(out_pop);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rp];

endmodule

>>> sv/lut_file_checker_decoder.sv
// Top level of the LUT file checker and decoder.
// Takes one file byte per cycle unless full; its result words pass the command queue, the
// back end's stage-one register and the result buffer. Sustained throughput is one byte and one
// result word per cycle while results are popped; an entry word comes before its status word.
// Synchronous active-low reset empties both queues and returns the parser to idle.
module lut_file_checker_decoder
    import lfcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_data_byte,
    input  logic                i_start_of_file,
    input  logic                i_end_of_stream,
    input  logic                pop,
    output logic                empty,
    output logic                o_kind,
    output logic [INDEX_W-1:0]  o_entry_index,
    output logic [VALUE_W-1:0]  o_red_value,
    output logic [VALUE_W-1:0]  o_green_value,
    output logic [VALUE_W-1:0]  o_blue_value,
    output logic [STATUS_W-1:0] o_file_status,
    output logic                o_last_result
);

    logic  accept, cmd_push, cmd_pop, cmd_empty;
    t_cmd  cmd_in, cmd_out;
    t_res  res;

    assign accept = push && !full;

    lfcd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_end_of_stream (i_end_of_stream),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    lfcd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty)
    );

    lfcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_kind        = res.kind;
    assign o_entry_index = res.index;
    assign o_red_value   = res.red;
    assign o_green_value = res.green;
    assign o_blue_value  = res.blue;
    assign o_file_status = res.status;
    assign o_last_result = res.last;

endmodule

>>> sv/lfcd_checker.sv
// Port-level checks for the LUT file checker and decoder.
module lfcd_port_checks
    import lfcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                pop,
    input  logic                empty,
    input  logic                o_kind,
    input  logic [INDEX_W-1:0]  o_entry_index,
    input  logic [VALUE_W-1:0]  o_red_value,
    input  logic [VALUE_W-1:0]  o_green_value,
    input  logic [VALUE_W-1:0]  o_blue_value,
    input  logic [STATUS_W-1:0] o_file_status,
    input  logic                o_last_result
);

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_STATUS) |->
            (o_last_result && o_entry_index == '0 && o_red_value == '0 &&
             o_green_value == '0 && o_blue_value == '0))
        else $error("status word carries entry fields");

    a_entry_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ENTRY) |-> (!o_last_result && o_file_status == ST_OK))
        else $error("entry word carries status fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_kind) && $stable(o_entry_index) &&
             $stable(o_red_value) && $stable(o_file_status)))
        else $error("waiting result word changed");

endmodule

bind lut_file_checker_decoder lfcd_port_checks u_lfcd_port_checks (.*);
